// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/fcps_pkg.sv
// Package: types, codes, constants and phase table of the command phase sequencer.
`timescale 1ns / 1ps
package fcps_pkg;

  localparam int unsigned TextDepth = 6;
  localparam int unsigned LenW      = 3;
  localparam int unsigned PosW      = 16;
  localparam int unsigned AccW      = PosW + 4;

  localparam logic [LenW-1:0] LenOver = LenW'(7);
  localparam logic [PosW-1:0] PosMax  = '1;

  localparam logic [7:0] ChOpen  = 8'h3C;
  localparam logic [7:0] ChClose = 8'h3E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChFive  = 8'h35;

  localparam logic [39:0] WordStart = "START";
  localparam logic [39:0] WordReady = "LISTO";
  localparam logic [39:0] WordReset = "RESET";
  localparam logic [31:0] WordBack  = "BACK";
  localparam logic [39:0] WordFase  = "FASE_";

  localparam logic [5:0] LimitLong  = 6'd50;
  localparam logic [5:0] LimitPiece = 6'd3;

  typedef enum logic [2:0] {
    PH_0 = 3'd0,
    PH_1 = 3'd1,
    PH_2 = 3'd2,
    PH_3 = 3'd3,
    PH_4 = 3'd4,
    PH_5 = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_START = 4'd1,
    CMD_READY = 4'd2,
    CMD_RESET = 4'd3,
    CMD_BACK  = 4'd4,
    CMD_TO1   = 4'd5,
    CMD_TO2   = 4'd6,
    CMD_TO3   = 4'd7,
    CMD_TO4   = 4'd8,
    CMD_TO5   = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    MOVE_NONE   = 3'd0,
    MOVE_CAMERA = 3'd1,
    MOVE_DRUM   = 3'd2,
    MOVE_PIECE  = 3'd3,
    MOVE_TABLE  = 3'd4
  } move_e;

  typedef struct packed {
    logic [2:0]      phase;
    logic [3:0]      command;
    logic            command_valid;
    logic            position_update;
    logic [PosW-1:0] position;
    logic [2:0]      move_kind;
    logic [5:0]      move_limit;
    logic            last_result;
  } res_t;

  // Up to two results handed from the core to the result queue together, in the same cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic       go;
    logic [2:0] phase;
  } step_t;

  function automatic step_t next_phase(input logic [2:0] p, input logic [3:0] c);
    step_t s;
    logic  to_one;
    to_one  = (c == CMD_BACK) || (c == CMD_RESET) || (c == CMD_TO1);
    s.go    = 1'b1;
    s.phase = PH_1;
    unique case (p)
      PH_0: begin
        s.go = to_one || (c == CMD_READY);
      end
      PH_1: begin
        priority if (c == CMD_TO2)   s.phase = PH_2;
        else if (c == CMD_TO3)       s.phase = PH_3;
        else if (c == CMD_TO4)       s.phase = PH_4;
        else if (c == CMD_TO5)       s.phase = PH_5;
        else if (c == CMD_START)     s.phase = PH_0;
        else                         s.go    = 1'b0;
      end
      PH_2, PH_4: begin
        priority if (to_one)         s.phase = PH_1;
        else if (c == CMD_TO3)       s.phase = PH_3;
        else if (c == CMD_TO5)       s.phase = PH_5;
        else if (c == CMD_START)     s.phase = PH_0;
        else                         s.go    = 1'b0;
      end
      PH_3: begin
        priority if (to_one)         s.phase = PH_1;
        else if (c == CMD_TO4)       s.phase = PH_4;
        else if (c == CMD_TO5)       s.phase = PH_5;
        else if (c == CMD_START)     s.phase = PH_0;
        else                         s.go    = 1'b0;
      end
      PH_5: begin
        priority if (to_one)         s.phase = PH_1;
        else if (c == CMD_START)     s.phase = PH_0;
        else                         s.go    = 1'b0;
      end
      default: begin
        s.go = 1'b0;
      end
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/fcps_if.sv
// Interfaces: received byte channel and result channel.
`timescale 1ns / 1ps
interface fcps_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcps_res_if;
  import fcps_pkg::*;
  logic            valid;
  logic            ready;
  logic [2:0]      phase;
  logic [3:0]      command;
  logic            command_valid;
  logic            position_update;
  logic [PosW-1:0] position;
  logic [2:0]      move_kind;
  logic [5:0]      move_limit;
  logic            last_result;

  modport source (output valid, output phase, output command, output command_valid,
                  output position_update, output position, output move_kind,
                  output move_limit, output last_result, input ready);
  modport sink   (input valid, input phase, input command, input command_valid,
                  input position_update, input position, input move_kind,
                  input move_limit, input last_result, output ready);
endinterface

// File: hw/rtl/fcps_core.sv
// Core: byte input register, message state and single-pass message handling.
`timescale 1ns / 1ps
module fcps_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  fcps_rx_if.sink         rx_i,
  input  logic [1:0]      free_i,
  output fcps_pkg::push_t push_o
);
  import fcps_pkg::*;

  logic            byte_vld_q;
  logic [7:0]      byte_q;
  logic [7:0]      text_q [TextDepth];
  logic            receiving_q, receiving_d;
  logic [LenW-1:0] len_q, len_d;
  logic            digits_q, digits_d;
  logic [PosW-1:0] acc_q, acc_d;
  logic [2:0]      phase_q, phase_d;
  logic [3:0]      prev_q, prev_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      move_q, move_d;
  logic [5:0]      limit_q, limit_d;

  logic            text_we;
  logic [AccW-1:0] acc_sum;
  logic [3:0]      cmd;
  logic [3:0]      new_prev;
  logic [7:0]      fase_off;
  logic [39:0]     text5;
  logic [31:0]     text4;
  step_t           nx;
  logic [1:0]      n_res;
  res_t            r0, r1;
  logic            fire;

  assign text5 = {text_q[0], text_q[1], text_q[2], text_q[3], text_q[4]};
  assign text4 = {text_q[0], text_q[1], text_q[2], text_q[3]};
  assign fase_off = text_q[5] - ChOne;

  always_comb begin
    priority if (len_q == LenW'(5) && text5 == WordStart)  cmd = CMD_START;
    else if (len_q == LenW'(5) && text5 == WordReady)      cmd = CMD_READY;
    else if (len_q == LenW'(5) && text5 == WordReset)      cmd = CMD_RESET;
    else if (len_q == LenW'(4) && text4 == WordBack)       cmd = CMD_BACK;
    else if (len_q == LenW'(6) && text5 == WordFase &&
             text_q[5] >= ChOne && text_q[5] <= ChFive)    cmd = CMD_TO1 + fase_off[3:0];
    else                                                   cmd = CMD_NONE;
  end

  assign new_prev = (cmd != CMD_NONE) ? cmd : prev_q;
  assign nx       = next_phase(phase_q, new_prev);
  assign acc_sum  = (AccW'(acc_q) << 3) + (AccW'(acc_q) << 1) + AccW'(byte_q - ChZero);

  always_comb begin
    receiving_d = receiving_q;
    len_d       = len_q;
    digits_d    = digits_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    move_d      = move_q;
    limit_d     = limit_q;
    text_we     = 1'b0;
    n_res       = 2'd0;
    r0          = '0;
    r1          = '0;
    if (!receiving_q) begin
      if (byte_q == ChOpen) begin
        receiving_d = 1'b1;
        len_d       = '0;
        digits_d    = 1'b1;
        acc_d       = '0;
      end
    end else if (byte_q != ChClose) begin
      text_we = (len_q < LenW'(TextDepth));
      if (len_q < LenOver) begin
        len_d = len_q + LenW'(1);
      end
      if (byte_q >= ChZero && byte_q <= ChNine) begin
        acc_d = (acc_sum > AccW'(PosMax)) ? PosMax : acc_sum[PosW-1:0];
      end else begin
        digits_d = 1'b0;
      end
    end else begin
      receiving_d = 1'b0;
      len_d       = '0;
      digits_d    = 1'b1;
      acc_d       = '0;
      n_res       = 2'd1;
      if ((phase_q == PH_2 || phase_q == PH_4) && digits_q) begin
        pos_d              = acc_q;
        r0.phase           = phase_q;
        r0.command         = prev_q;
        r0.command_valid   = 1'b0;
        r0.position_update = 1'b1;
        r0.position        = acc_q;
        r0.move_kind       = move_q;
        r0.move_limit      = limit_q;
        r0.last_result     = 1'b1;
      end else begin
        prev_d = new_prev;
        if (nx.go) begin
          phase_d = nx.phase;
          unique case (nx.phase)
            PH_2: begin
              move_d  = MOVE_CAMERA;
              limit_d = LimitLong;
            end
            PH_3: begin
              move_d  = MOVE_DRUM;
              limit_d = LimitLong;
            end
            PH_4: begin
              move_d  = MOVE_TABLE;
              limit_d = LimitLong;
              n_res   = 2'd2;
            end
            default: ;
          endcase
        end
        r0.phase           = phase_d;
        r0.command         = new_prev;
        r0.command_valid   = (cmd != CMD_NONE);
        r0.position_update = 1'b0;
        r0.position        = pos_q;
        r0.move_kind       = move_d;
        r0.move_limit      = limit_d;
        r0.last_result     = 1'b1;
        r1                 = r0;
        if (n_res == 2'd2) begin
          r0.move_kind   = MOVE_PIECE;
          r0.move_limit  = LimitPiece;
          r0.last_result = 1'b0;
        end
      end
    end
  end

  assign fire       = byte_vld_q && (n_res <= free_i);
  assign rx_i.ready = !byte_vld_q || fire;

  assign push_o.count  = fire ? n_res : 2'd0;
  assign push_o.first  = r0;
  assign push_o.second = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q  <= 1'b0;
      receiving_q <= 1'b0;
      len_q       <= '0;
      digits_q    <= 1'b1;
      acc_q       <= '0;
      phase_q     <= PH_0;
      prev_q      <= CMD_NONE;
      pos_q       <= '0;
      move_q      <= MOVE_NONE;
      limit_q     <= '0;
    end else begin
      if (rx_i.ready) begin
        byte_vld_q <= rx_i.valid;
      end
      if (fire) begin
        receiving_q <= receiving_d;
        len_q       <= len_d;
        digits_q    <= digits_d;
        acc_q       <= acc_d;
        phase_q     <= phase_d;
        prev_q      <= prev_d;
        pos_q       <= pos_d;
        move_q      <= move_d;
        limit_q     <= limit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
    if (fire && text_we) begin
      text_q[len_q] <= byte_q;
    end
  end

endmodule

// File: hw/rtl/fcps_res_queue.sv
// Two-entry result queue between the core and the result channel.
`timescale 1ns / 1ps
module fcps_res_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fcps_pkg::push_t push_i,
  output logic [1:0]      free_o,
  fcps_res_if.source      res_o
);
  import fcps_pkg::*;

  res_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  res_t       head;

  assign head   = entry_q[rd_q];
  assign pop    = res_o.valid && res_o.ready;
  assign free_o = 2'd2 - cnt_q;
  assign cnt_d  = cnt_q + push_i.count - {1'b0, pop};

  assign res_o.valid           = (cnt_q != 2'd0);
  assign res_o.phase           = head.phase;
  assign res_o.command         = head.command;
  assign res_o.command_valid   = head.command_valid;
  assign res_o.position_update = head.position_update;
  assign res_o.position        = head.position;
  assign res_o.move_kind       = head.move_kind;
  assign res_o.move_limit      = head.move_limit;
  assign res_o.last_result     = head.last_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_q ^ push_i.count[0];
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entry_q[!wr_q] <= push_i.second;
    end
  end

endmodule

// File: hw/rtl/framed_command_phase_sequencer_top.sv
// Top level: framed command phase sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one received byte per transfer and may take a new byte every cycle while the
// queue has room for all results of the byte it holds. A byte is registered in the input
// register, handled from there, and its results land in a two-entry queue, from whose
// registers the first result of a closing '>' is offered on the result channel. Most
// bytes give no result; a message that enters phase 4 gives two. The queue sets the
// sustained rate: one result per cycle leaves the block while the result channel is
// ready, and a byte waits in the input register until the queue has room for all of its results.
module framed_command_phase_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcps_rx_if.sink    rx_i,
  fcps_res_if.source res_o
);
  import fcps_pkg::*;

  push_t      push;
  logic [1:0] free;

  fcps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .free_i (free),
    .push_o (push)
  );

  fcps_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (free),
    .res_o  (res_o)
  );

  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push.count != 2'd0, push.count <= free)
  `ASSERT_IMPLIES(a_pair_marks, clk_i, rst_ni, push.count == 2'd2, !push.first.last_result && push.second.last_result)
  `ASSERT_IMPLIES(a_single_last, clk_i, rst_ni, push.count == 2'd1, push.first.last_result)
  `ASSERT_NEXT(a_pair_lands, clk_i, rst_ni, push.count == 2'd2, res_o.valid)

endmodule

// File: tb/framed_command_phase_sequencer_top_test.sv
// Testbench: framed command phase sequencer, byte stream in, checked phase results out.
`timescale 1ns / 1ps
module framed_command_phase_sequencer_top_test;
  import fcps_pkg::*;

  localparam int unsigned ItemsTarget = 1650;
  localparam int unsigned QuietTail   = 150;

  class phase_scoreboard;
    res_t        expected_q[$];
    bit          in_frame;
    logic [7:0]  text[TextDepth];
    logic [2:0]  text_len;
    bit          all_digits;
    int unsigned acc;
    phase_e      phase;
    cmd_e        last_cmd;
    logic [15:0] target;
    move_e       move;
    logic [5:0]  limit;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned phase4_entries;
    int unsigned position_sets;

    function new();
      in_frame       = 1'b0;
      text_len       = '0;
      all_digits     = 1'b1;
      acc            = 0;
      phase          = PH_0;
      last_cmd       = CMD_NONE;
      target         = '0;
      move           = MOVE_NONE;
      limit          = '0;
      mismatches     = 0;
      checked        = 0;
      phase4_entries = 0;
      position_sets  = 0;
      foreach (text[i]) text[i] = '0;
    endfunction

    function void clear_text();
      text_len   = '0;
      all_digits = 1'b1;
      acc        = 0;
    endfunction

    // First n stored characters against a right-aligned word of n characters.
    function bit prefix_is(logic [39:0] w, int n);
      for (int i = 0; i < n; i++)
        if (text[i] !== w[8*(n-1-i) +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function cmd_e decode();
      if (text_len == 5 && prefix_is(WordStart, 5)) return CMD_START;
      if (text_len == 5 && prefix_is(WordReady, 5)) return CMD_READY;
      if (text_len == 5 && prefix_is(WordReset, 5)) return CMD_RESET;
      if (text_len == 4 && prefix_is({8'h00, WordBack}, 4)) return CMD_BACK;
      if (text_len == 6 && prefix_is(WordFase, 5) && text[5] >= ChOne && text[5] <= ChFive)
        return cmd_e'(CMD_TO1 + (text[5] - ChOne));
      return CMD_NONE;
    endfunction

    function bit next_phase_of(phase_e p, cmd_e c, output phase_e np);
      bit to_one;
      to_one = (c == CMD_BACK) || (c == CMD_RESET) || (c == CMD_TO1);
      np     = PH_1;
      case (p)
        PH_0: return to_one || (c == CMD_READY);
        PH_1: begin
          case (c)
            CMD_TO2:   np = PH_2;
            CMD_TO3:   np = PH_3;
            CMD_TO4:   np = PH_4;
            CMD_TO5:   np = PH_5;
            CMD_START: np = PH_0;
            default:   return 1'b0;
          endcase
          return 1'b1;
        end
        PH_2, PH_4, PH_3: begin
          if (to_one) return 1'b1;
          if (c == CMD_TO5) begin np = PH_5; return 1'b1; end
          if (c == CMD_START) begin np = PH_0; return 1'b1; end
          if (p != PH_3 && c == CMD_TO3) begin np = PH_3; return 1'b1; end
          if (p == PH_3 && c == CMD_TO4) begin np = PH_4; return 1'b1; end
          return 1'b0;
        end
        PH_5: begin
          if (to_one) return 1'b1;
          if (c == CMD_START) begin np = PH_0; return 1'b1; end
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void push(bit valid, bit upd, move_e mk, logic [5:0] lim, bit last);
      res_t r;
      r.phase           = phase;
      r.command         = last_cmd;
      r.command_valid   = valid;
      r.position_update = upd;
      r.position        = target;
      r.move_kind       = mk;
      r.move_limit      = lim;
      r.last_result     = last;
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      cmd_e   c;
      phase_e np;
      if (!in_frame) begin
        if (b == ChOpen) begin
          in_frame = 1'b1;
          clear_text();
        end
        return;
      end
      if (b != ChClose) begin
        if (text_len < TextDepth) text[text_len] = b;
        if (text_len < LenOver) text_len++;
        if (b >= ChZero && b <= ChNine) begin
          acc = acc * 10 + (b - ChZero);
          if (acc > PosMax) acc = PosMax;
        end else begin
          all_digits = 1'b0;
        end
        return;
      end
      in_frame = 1'b0;
      if ((phase == PH_2 || phase == PH_4) && all_digits) begin
        target = acc[15:0];
        clear_text();
        position_sets++;
        push(1'b0, 1'b1, move, limit, 1'b1);
        return;
      end
      c = decode();
      clear_text();
      if (c != CMD_NONE) last_cmd = c;
      if (next_phase_of(phase, last_cmd, np)) begin
        phase = np;
        case (np)
          PH_2: begin move = MOVE_CAMERA; limit = LimitLong; end
          PH_3: begin move = MOVE_DRUM; limit = LimitLong; end
          PH_4: begin
            push(c != CMD_NONE, 1'b0, MOVE_PIECE, LimitPiece, 1'b0);
            move  = MOVE_TABLE;
            limit = LimitLong;
            phase4_entries++;
          end
          default: ;
        endcase
      end
      push(c != CMD_NONE, 1'b0, move, limit, 1'b1);
    endfunction

    function string show(res_t r);
      return $sformatf("ph=%0d cmd=%0d cv=%0d pu=%0d pos=%0d mk=%0d lim=%0d last=%0d",
                       r.phase, r.command, r.command_valid, r.position_update,
                       r.position, r.move_kind, r.move_limit, r.last_result);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      bit   bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %s", $time, show(got));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      bad = (got.phase !== exp.phase) || (got.command !== exp.command) ||
            (got.command_valid !== exp.command_valid) ||
            (got.position_update !== exp.position_update) ||
            (got.position !== exp.position) || (got.move_kind !== exp.move_kind) ||
            (got.move_limit !== exp.move_limit) || (got.last_result !== exp.last_result);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fcps_rx_if  rx();
  fcps_res_if res();

  framed_command_phase_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  phase_scoreboard sb = new();

  bit          idle_on = 1'b1;
  int unsigned sent    = 0;
  int unsigned frames  = 0;

  string words[9] = '{"START", "LISTO", "RESET", "BACK", "FASE_1", "FASE_2", "FASE_3",
                      "FASE_4", "FASE_5"};

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.phase           = res.phase;
      got.command         = res.command;
      got.command_valid   = res.command_valid;
      got.position_update = res.position_update;
      got.position        = res.position;
      got.move_kind       = res.move_kind;
      got.move_limit      = res.move_limit;
      got.last_result     = res.last_result;
      sb.check_result(got);
    end
  end

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit counts);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    sb.note_byte(b);
    if (counts) sent++;
  endtask

  task automatic send_frame(input logic [7:0] body[$], input bit closed);
    send_byte(ChOpen, 1'b1);
    foreach (body[i]) send_byte(body[i], 1'b1);
    if (closed) begin
      send_byte(ChClose, 1'b1);
      frames++;
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] body[$];
    for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    send_frame(body, 1'b1);
  endtask

  // Any byte that cannot close a frame.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == ChClose) ? 8'h3F : b;
  endfunction

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned next_seg;
    string       w;
    logic [7:0]  body[$];

    rst_ni     = 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray bytes, READY, entry into phase 4, saturated and empty positions
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("LISTO");
    send_text("FASE_4");
    send_text("99999");
    send_text("");

    next_seg = 0;
    while (sent < ItemsTarget) begin
      if (sent >= next_seg) begin
        idle_on  = (sent + QuietTail < ItemsTarget) && ($urandom_range(0, 3) != 0);
        next_seg += 100;
      end
      pick = $urandom_range(0, 99);
      body.delete();
      if (pick < 55) begin
        send_text(words[$urandom_range(0, 8)]);
      end else if (pick < 72) begin
        n = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) send_text($urandom_range(0, 1) ? "65535" : "65536");
        else begin
          repeat (n) body.push_back(8'(ChZero + $urandom_range(0, 9)));
          send_frame(body, 1'b1);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(0, 9)) body.push_back(text_byte());
        send_frame(body, 1'b1);
      end else if (pick < 88) begin
        w = words[$urandom_range(0, 8)];
        for (int i = 0; i < w.len(); i++) body.push_back(w[i]);
        case ($urandom_range(0, 3))
          0: body[$urandom_range(0, body.size() - 1)] = text_byte();
          1: body.push_back(text_byte());
          2: void'(body.pop_back());
          default: begin
            body = '{8'h46, 8'h41, 8'h53, 8'h45, 8'h5F};
            body.push_back($urandom_range(0, 1) ? ChZero
                                                : 8'(ChFive + $urandom_range(1, 4)));
          end
        endcase
        send_frame(body, 1'b1);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 4)) begin
          n = $urandom_range(0, 255);
          send_byte((n == ChOpen) ? 8'h80 : n[7:0], 1'b0);
        end
      end else begin
        // open frame left unterminated; the next opener lands in its text
        repeat ($urandom_range(0, 3)) body.push_back(text_byte());
        send_frame(body, 1'b0);
      end
    end

    rx.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d framed bytes in %0d closed messages; %0d results checked.",
             sent, frames, sb.checked);
    $display("Phase 4 entries: %0d, position updates: %0d, mismatches: %0d.",
             sb.phase4_entries, sb.position_sets, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: framed_command_phase_sequencer_top.f
+incdir+hw/rtl
hw/rtl/fcps_pkg.sv
hw/rtl/fcps_if.sv
hw/rtl/fcps_core.sv
hw/rtl/fcps_res_queue.sv
hw/rtl/framed_command_phase_sequencer_top.sv
tb/framed_command_phase_sequencer_top_test.sv
